FILE: sv/arpc_pkg.sv
`default_nettype none
package arpc_pkg;

    localparam int ENTRIES_DEF = 16;

    localparam logic [15:0] VALIDITY_RST = 16'd300;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] ip_addr;
        logic [47:0] mac_addr;
    } t_in_beat;

    typedef struct packed {
        logic        status;
        logic        hit;
        logic [47:0] mac_out;
    } t_out_beat;

    // write controls from the sequencer to the table
    typedef struct packed {
        logic entry_we;
        logic timer_we;
        logic clr_valid;
    } t_tbl_ctl;

endpackage
`default_nettype wire

FILE: sv/arpc_table.sv
`default_nettype none
module arpc_table #(
    parameter int ENTRIES = arpc_pkg::ENTRIES_DEF
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire [$clog2(ENTRIES)-1:0] i_rd_addr,
    input  wire [$clog2(ENTRIES)-1:0] i_wr_idx,
    input  wire arpc_pkg::t_tbl_ctl   i_ctl,
    input  wire [31:0]                i_wr_ip,
    input  wire [47:0]                i_wr_mac,
    input  wire [15:0]                i_wr_timer,
    output logic [31:0]               o_rd_ip,
    output logic [47:0]               o_rd_mac,
    output logic [15:0]               o_rd_timer,
    output logic                      o_rd_valid,
    output logic                      o_rd_perm
);

    localparam int IW = $clog2(ENTRIES);

    logic [31:0] r_ip_mem    [ENTRIES];
    logic [47:0] r_mac_mem   [ENTRIES];
    logic [15:0] r_timer_mem [ENTRIES];

    logic [ENTRIES-1:0] r_valid;
    logic [ENTRIES-1:0] r_perm;
    logic               r_bcast;

    logic [31:0] r_rd_ip;
    logic [47:0] r_rd_mac;
    logic        r_rd_bcast;

    always_ff @(posedge i_clk) begin
        if (i_ctl.entry_we) begin
            r_ip_mem[i_wr_idx]  <= i_wr_ip;
            r_mac_mem[i_wr_idx] <= i_wr_mac;
        end
        if (i_ctl.entry_we || i_ctl.timer_we) begin
            r_timer_mem[i_wr_idx] <= i_wr_timer;
        end
        r_rd_ip    <= r_ip_mem[i_rd_addr];
        r_rd_mac   <= r_mac_mem[i_rd_addr];
        o_rd_timer <= r_timer_mem[i_rd_addr];
    end

    // slot 0 reads as the broadcast entry until an add rewrites it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= {{(ENTRIES-1){1'b0}}, 1'b1};
            r_perm     <= {{(ENTRIES-1){1'b0}}, 1'b1};
            r_bcast    <= 1'b1;
            r_rd_bcast <= 1'b0;
            o_rd_valid <= 1'b0;
            o_rd_perm  <= 1'b0;
        end else begin
            if (i_ctl.entry_we) begin
                r_valid[i_wr_idx] <= 1'b1;
                r_perm[i_wr_idx]  <= 1'b0;
                if (i_wr_idx == IW'(0)) begin
                    r_bcast <= 1'b0;
                end
            end else if (i_ctl.clr_valid) begin
                r_valid[i_wr_idx] <= 1'b0;
            end
            r_rd_bcast <= r_bcast && (i_rd_addr == IW'(0));
            o_rd_valid <= r_valid[i_rd_addr];
            o_rd_perm  <= r_perm[i_rd_addr];
        end
    end

    assign o_rd_ip  = r_rd_bcast ? '1 : r_rd_ip;
    assign o_rd_mac = r_rd_bcast ? '1 : r_rd_mac;

endmodule
`default_nettype wire

FILE: sv/arpc_seq.sv
`default_nettype none
module arpc_seq #(
    parameter int ENTRIES = arpc_pkg::ENTRIES_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_start,
    input  wire arpc_pkg::t_in_beat    i_item,
    input  wire [15:0]                 i_validity,
    input  wire                        i_out_free,
    output logic                       o_idle,
    output logic                       o_res_valid,
    output arpc_pkg::t_out_beat        o_res,
    output logic [$clog2(ENTRIES)-1:0] o_rd_addr,
    output logic [$clog2(ENTRIES)-1:0] o_wr_idx,
    output arpc_pkg::t_tbl_ctl         o_ctl,
    output logic [31:0]                o_wr_ip,
    output logic [47:0]                o_wr_mac,
    output logic [15:0]                o_wr_timer,
    input  wire [31:0]                 i_rd_ip,
    input  wire [47:0]                 i_rd_mac,
    input  wire [15:0]                 i_rd_timer,
    input  wire                        i_rd_valid,
    input  wire                        i_rd_perm
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state      r_state;
    logic [1:0]  r_op;
    logic [31:0] r_ip;
    logic [47:0] r_mac;
    logic [CW-1:0] r_rd_cnt;
    logic        r_chk_vld;
    logic [IW-1:0] r_chk_idx;
    logic        r_hit;
    logic [IW-1:0] r_hit_idx;
    logic [47:0] r_hit_mac;
    logic        r_free;
    logic [IW-1:0] r_free_idx;

    logic        match;
    logic        aging;
    logic [15:0] timer_dec;
    logic        do_finish;
    logic        add_ok;

    // shared compare and decrement unit, one slot per cycle
    assign match     = r_chk_vld && i_rd_valid && (i_rd_ip == r_ip);
    assign aging     = r_chk_vld && (r_op == arpc_pkg::OP_TICK) && i_rd_valid && !i_rd_perm;
    assign timer_dec = (i_rd_timer == 16'd0) ? 16'd0 : i_rd_timer - 16'd1;

    assign do_finish = (r_state == S_DONE) && i_out_free;
    assign add_ok    = r_hit || r_free;
    assign o_idle    = (r_state == S_IDLE);
    assign o_rd_addr = r_rd_cnt[IW-1:0];

    always_comb begin
        o_ctl      = '0;
        o_wr_idx   = r_chk_idx;
        o_wr_ip    = r_ip;
        o_wr_mac   = r_mac;
        o_wr_timer = timer_dec;
        if (aging) begin
            o_ctl.timer_we  = 1'b1;
            o_ctl.clr_valid = (timer_dec == 16'd0);
        end
        if (do_finish && (r_op == arpc_pkg::OP_ADD) && add_ok) begin
            o_ctl.entry_we = 1'b1;
            o_wr_idx       = r_hit ? r_hit_idx : r_free_idx;
            o_wr_timer     = i_validity;
        end
    end

    always_comb begin
        o_res_valid = do_finish;
        o_res       = '0;
        o_res.status = arpc_pkg::STATUS_DONE;
        case (r_op)
            arpc_pkg::OP_ADD: begin
                o_res.status = add_ok ? arpc_pkg::STATUS_DONE : arpc_pkg::STATUS_FULL;
            end
            arpc_pkg::OP_LOOKUP: begin
                o_res.hit     = r_hit;
                o_res.mac_out = r_hit ? r_hit_mac : 48'd0;
            end
            default: begin
                o_res.hit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_chk_vld <= 1'b0;
            r_hit     <= 1'b0;
            r_free    <= 1'b0;
            r_rd_cnt  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_op      <= i_item.op;
                        r_ip      <= i_item.ip_addr;
                        r_mac     <= i_item.mac_addr;
                        r_rd_cnt  <= '0;
                        r_chk_vld <= 1'b0;
                        r_hit     <= 1'b0;
                        r_free    <= 1'b0;
                        r_state   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_rd_cnt == CW'(ENTRIES)) begin
                        r_chk_vld <= 1'b0;
                        r_state   <= S_DONE;
                    end else begin
                        r_chk_vld <= 1'b1;
                        r_chk_idx <= r_rd_cnt[IW-1:0];
                        r_rd_cnt  <= r_rd_cnt + CW'(1);
                    end
                    // lowest matching slot and lowest free slot
                    if (match && !r_hit) begin
                        r_hit     <= 1'b1;
                        r_hit_idx <= r_chk_idx;
                        r_hit_mac <= i_rd_mac;
                    end
                    if (r_chk_vld && !i_rd_valid && !r_free) begin
                        r_free     <= 1'b1;
                        r_free_idx <= r_chk_idx;
                    end
                end
                S_DONE: begin
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: sv/arp_cache_with_aging_top.sv
// an input beat is taken only while the sequencer is idle; it then scans the table,
//   one slot a cycle through the single read port and the shared compare unit,
//   and the result goes to the output register o_out_valid / o_out once the
//   output is free; the next beat is taken only after that
// reset: synchronous, active low; slot 0 holds the permanent broadcast entry,
//   all other slots free, r_validity back to 300; no clearing pass
`default_nettype none
module arp_cache_with_aging_top #(
    parameter int ENTRIES = arpc_pkg::ENTRIES_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  wire arpc_pkg::t_in_beat i_in,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output arpc_pkg::t_out_beat  o_out,
    input  wire                  i_cfg_we,
    input  wire [15:0]           i_cfg_wdata
);

    localparam int IW = $clog2(ENTRIES);

    logic [15:0]          r_validity;
    logic                 r_out_vld;
    arpc_pkg::t_out_beat  r_out;

    logic                 seq_idle;
    logic                 res_valid;
    arpc_pkg::t_out_beat  res;
    logic [IW-1:0]        rd_addr;
    logic [IW-1:0]        wr_idx;
    arpc_pkg::t_tbl_ctl   ctl;
    logic [31:0]          wr_ip;
    logic [47:0]          wr_mac;
    logic [15:0]          wr_timer;
    logic [31:0]          rd_ip;
    logic [47:0]          rd_mac;
    logic [15:0]          rd_timer;
    logic                 rd_valid;
    logic                 rd_perm;
    logic                 out_free;

    assign o_in_ready  = seq_idle;
    assign out_free    = !r_out_vld || i_out_ready;
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_validity <= arpc_pkg::VALIDITY_RST;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_validity <= i_cfg_wdata;
            end
            if (res_valid) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    arpc_seq #(
        .ENTRIES(ENTRIES)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_in_valid && seq_idle),
        .i_item      (i_in),
        .i_validity  (r_validity),
        .i_out_free  (out_free),
        .o_idle      (seq_idle),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_rd_addr   (rd_addr),
        .o_wr_idx    (wr_idx),
        .o_ctl       (ctl),
        .o_wr_ip     (wr_ip),
        .o_wr_mac    (wr_mac),
        .o_wr_timer  (wr_timer),
        .i_rd_ip     (rd_ip),
        .i_rd_mac    (rd_mac),
        .i_rd_timer  (rd_timer),
        .i_rd_valid  (rd_valid),
        .i_rd_perm   (rd_perm)
    );

    arpc_table #(
        .ENTRIES(ENTRIES)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_addr  (rd_addr),
        .i_wr_idx   (wr_idx),
        .i_ctl      (ctl),
        .i_wr_ip    (wr_ip),
        .i_wr_mac   (wr_mac),
        .i_wr_timer (wr_timer),
        .o_rd_ip    (rd_ip),
        .o_rd_mac   (rd_mac),
        .o_rd_timer (rd_timer),
        .o_rd_valid (rd_valid),
        .o_rd_perm  (rd_perm)
    );

endmodule
`default_nettype wire

FILE: tb/tb_arp_cache_with_aging_top.sv
module tb_arp_cache_with_aging_top;
    timeunit 1ns;
    timeprecision 1ps;

    import arpc_pkg::*;

    localparam int          NSLOTS    = ENTRIES_DEF;
    localparam logic [1:0]  OP_UNUSED = 2'd3;
    localparam logic [31:0] BCAST_IP  = 32'hFFFF_FFFF;
    localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;
    localparam int          POOL_SIZE = 24;
    localparam int          CHUNK     = 122;

    class arp_cache_scoreboard;
        bit          slot_live[NSLOTS];
        bit [31:0]   slot_ip[NSLOTS];
        bit [47:0]   slot_mac[NSLOTS];
        bit [15:0]   slot_timer[NSLOTS];
        bit          slot_pinned[NSLOTS];
        bit [15:0]   load_ticks;
        t_out_beat   pending_replies[$];
        int          errors;
        int          n_add, n_full, n_lookup, n_hit, n_tick, n_expired, n_unused;

        function new();
            foreach (slot_live[s]) begin
                slot_live[s]   = 1'b0;
                slot_pinned[s] = 1'b0;
            end
            // broadcast entry is permanent from reset
            slot_live[0]   = 1'b1;
            slot_ip[0]     = BCAST_IP;
            slot_mac[0]    = BCAST_MAC;
            slot_pinned[0] = 1'b1;
            load_ticks     = VALIDITY_RST;
        endfunction

        function int find_entry(bit [31:0] ip);
            for (int s = 0; s < NSLOTS; s++)
                if (slot_live[s] && slot_ip[s] == ip)
                    return s;
            return -1;
        endfunction

        function t_out_beat resolve_arp_op(t_in_beat req);
            t_out_beat rsp;
            int        s;
            rsp = '0;
            case (req.op)
                OP_ADD: begin
                    n_add++;
                    s = find_entry(req.ip_addr);
                    if (s < 0)
                        for (int k = NSLOTS - 1; k >= 0; k--)
                            if (!slot_live[k])
                                s = k;
                    if (s < 0) begin
                        rsp.status = STATUS_FULL;
                        n_full++;
                    end else begin
                        slot_live[s]   = 1'b1;
                        slot_ip[s]     = req.ip_addr;
                        slot_mac[s]    = req.mac_addr;
                        slot_timer[s]  = load_ticks;
                        slot_pinned[s] = 1'b0;
                        rsp.status     = STATUS_DONE;
                    end
                end
                OP_LOOKUP: begin
                    n_lookup++;
                    s = find_entry(req.ip_addr);
                    if (s >= 0) begin
                        rsp.hit     = 1'b1;
                        rsp.mac_out = slot_mac[s];
                        n_hit++;
                    end
                end
                OP_TICK: begin
                    n_tick++;
                    for (int k = 0; k < NSLOTS; k++)
                        if (slot_live[k] && !slot_pinned[k]) begin
                            if (slot_timer[k] != 0)
                                slot_timer[k]--;
                            if (slot_timer[k] == 0) begin
                                slot_live[k] = 1'b0;
                                n_expired++;
                            end
                        end
                end
                default: n_unused++;
            endcase
            return rsp;
        endfunction

        function void note_request(t_in_beat req);
            pending_replies.push_back(resolve_arp_op(req));
        endfunction

        function void flag_error(string msg);
            errors++;
            if (errors <= 10)
                $display("[%0t] mismatch: %s", $realtime, msg);
        endfunction

        function void check_reply(t_out_beat got);
            t_out_beat want;
            if (pending_replies.size() == 0) begin
                flag_error($sformatf("unexpected reply status=%0b hit=%0b mac=%012h",
                                     got.status, got.hit, got.mac_out));
                return;
            end
            want = pending_replies.pop_front();
            if (got.status !== want.status)
                flag_error($sformatf("status exp %0b got %0b", want.status, got.status));
            if (got.hit !== want.hit)
                flag_error($sformatf("hit exp %0b got %0b", want.hit, got.hit));
            if (got.mac_out !== want.mac_out)
                flag_error($sformatf("mac_out exp %012h got %012h",
                                     want.mac_out, got.mac_out));
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    t_in_beat    i_in        = '0;
    logic        i_out_ready = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [15:0] i_cfg_wdata = '0;
    logic        o_in_ready;
    logic        o_out_valid;
    t_out_beat   o_out;

    arp_cache_scoreboard sb;
    bit [31:0]           ip_pool[POOL_SIZE];
    int                  tx_idle_pct     = 0;
    int                  rx_idle_pct     = 0;
    int                  rx_hold_request = 0;

    arp_cache_with_aging_top #(.ENTRIES(NSLOTS)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                sb.check_reply(o_out);
            if (i_in_valid && o_in_ready)
                sb.note_request(i_in);
        end
    end

    // result side: random stalls, plus a long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_request > 0) begin
                hold_left       = rx_hold_request;
                rx_hold_request = 0;
            end
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else begin
                i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d replies outstanding", sb.pending_replies.size());
        $display("tb_arp_cache_with_aging_top NOT OK");
        $finish;
    end

    function automatic t_in_beat make_req(logic [1:0] op, logic [31:0] ip, logic [47:0] mac);
        t_in_beat r;
        r.op       = op;
        r.ip_addr  = ip;
        r.mac_addr = mac;
        return r;
    endfunction

    function automatic t_in_beat random_req();
        int          pick;
        int          src;
        logic [31:0] ip;
        logic [47:0] mac;
        pick = $urandom_range(99);
        src  = $urandom_range(99);
        mac  = {16'($urandom), 32'($urandom)};
        ip   = 32'($urandom);
        if (pick < 42) begin
            // adds stay on a small address set so updates, aging and table full all occur
            ip = (src < 85) ? ip_pool[$urandom_range(POOL_SIZE - 1)] : BCAST_IP;
            return make_req(OP_ADD, ip, mac);
        end
        if (pick < 77) begin
            if (src < 70)
                ip = ip_pool[$urandom_range(POOL_SIZE - 1)];
            else if (src < 80)
                ip = BCAST_IP;
            return make_req(OP_LOOKUP, ip, mac);
        end
        if (pick < 96)
            return make_req(OP_TICK, ip, mac);
        return make_req(OP_UNUSED, ip, mac);
    endfunction

    task automatic send_req(input t_in_beat req);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in       <= req;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain_replies();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_replies.size() != 0);
    endtask

    task automatic set_validity(input logic [15:0] ticks);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= ticks;
        @(posedge i_clk);
        i_cfg_we       <= 1'b0;
        sb.load_ticks   = ticks;
    endtask

    initial begin
        int validity_plan[9];
        validity_plan = '{4, 0, 65535, 2, 7, 1, 300, 3, 5};
        sb = new();
        ip_pool[0] = 32'h0000_0000;
        ip_pool[1] = 32'hFFFF_FFFE;
        for (int i = 2; i < POOL_SIZE; i++)
            ip_pool[i] = {8'(i), 24'($urandom)};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_validity(VALIDITY_RST);

        // directed: broadcast entry, extremes, update, unused op, fill to full
        send_req(make_req(OP_LOOKUP, BCAST_IP, '0));
        send_req(make_req(OP_TICK, '0, '0));
        send_req(make_req(OP_ADD, ip_pool[0], 48'h0));
        send_req(make_req(OP_ADD, ip_pool[1], BCAST_MAC));
        send_req(make_req(OP_LOOKUP, ip_pool[0], '0));
        send_req(make_req(OP_LOOKUP, 32'h0A00_0001, BCAST_MAC));
        send_req(make_req(OP_ADD, ip_pool[0], 48'h0123_4567_89AB));
        send_req(make_req(OP_LOOKUP, ip_pool[0], '0));
        send_req(make_req(OP_UNUSED, BCAST_IP, BCAST_MAC));
        for (int i = 2; i <= 14; i++)
            send_req(make_req(OP_ADD, ip_pool[i], {16'(i), 32'($urandom)}));
        send_req(make_req(OP_ADD, ip_pool[15], 48'hA5A5_A5A5_A5A5));
        // match still updates when the table is full
        send_req(make_req(OP_ADD, ip_pool[1], 48'h5A5A_5A5A_5A5A));
        drain_replies();

        // zero validity on the broadcast slot: it loses its pin and dies at the next tick
        set_validity(16'd0);
        send_req(make_req(OP_ADD, BCAST_IP, 48'h0000_5E00_0001));
        send_req(make_req(OP_LOOKUP, BCAST_IP, '0));
        send_req(make_req(OP_TICK, BCAST_IP, '0));
        send_req(make_req(OP_LOOKUP, BCAST_IP, '0));
        send_req(make_req(OP_LOOKUP, ip_pool[3], '0));
        drain_replies();

        for (int regime = 0; regime < 3; regime++) begin
            tx_idle_pct = (regime == 0) ? 24 : (regime == 1) ? 56 : 0;
            rx_idle_pct = (regime == 0) ? 56 : (regime == 1) ? 24 : 0;
            for (int c = 0; c < 3; c++) begin
                set_validity(16'(validity_plan[regime * 3 + c]));
                // long output stall while beats keep coming, backs up the input
                if (regime == 2 && c == 0)
                    rx_hold_request = 300;
                for (int n = 0; n < CHUNK; n++)
                    send_req(random_req());
                drain_replies();
            end
        end

        repeat (2 * (NSLOTS + 2)) @(posedge i_clk);
        $display("ran %0d adds (%0d table full), %0d lookups (%0d hits), %0d ticks,",
                 sb.n_add, sb.n_full, sb.n_lookup, sb.n_hit, sb.n_tick);
        $display("%0d unused ops, %0d entries aged out over validity 0..65535, %0d mismatches",
                 sb.n_unused, sb.n_expired, sb.errors);
        if (sb.errors == 0)
            $display("tb_arp_cache_with_aging_top OK");
        else
            $display("tb_arp_cache_with_aging_top NOT OK");
        $finish;
    end

endmodule
